// ===== rtl/dncu_pkg.sv =====
// ----------------------------------------------------------------------------
// dncu_pkg
// Shared types, fault codes and character class functions for the dotted
// NCName UTF-8 checker.
// ----------------------------------------------------------------------------
package dncu_pkg;

   // fault cause codes
   typedef logic [1:0] fault_type;
   localparam fault_type FaultNone  = 2'd0;
   localparam fault_type FaultUtf8  = 2'd1;
   localparam fault_type FaultName  = 2'd2;
   localparam fault_type FaultEmpty = 2'd3;

   typedef logic [20:0] code_point_type;

   // byte classes
   localparam logic [7:0] DotByte      = 8'h2e;
   localparam logic [7:0] LeadTwoLow   = 8'hc2;
   localparam logic [7:0] LeadTwoHigh  = 8'hdf;
   localparam logic [7:0] LeadThreeLow = 8'he0;
   localparam logic [7:0] LeadFourLow  = 8'hf0;
   localparam logic [7:0] LeadFourHigh = 8'hf4;

   // code point limits
   localparam code_point_type MinThreeByte  = 21'h000800;
   localparam code_point_type MinFourByte   = 21'h010000;
   localparam code_point_type SurrogateLow  = 21'h00d800;
   localparam code_point_type SurrogateHigh = 21'h00dfff;
   localparam code_point_type MaxCodePoint  = 21'h10ffff;

   // sequence lengths, counted in continuation bytes
   localparam logic [1:0] SeqTwoByte   = 2'd1;
   localparam logic [1:0] SeqThreeByte = 2'd2;
   localparam logic [1:0] SeqFourByte  = 2'd3;

   // xml ncname start character
   function automatic logic dncu_name_start(input code_point_type c);
      return (c == 21'h5f) || (c >= 21'h41 && c <= 21'h5a) ||
             (c >= 21'h61 && c <= 21'h7a) ||
             (c >= 21'hc0 && c <= 21'hd6) || (c >= 21'hd8 && c <= 21'hf6) ||
             (c >= 21'hf8 && c <= 21'h2ff) || (c >= 21'h370 && c <= 21'h37d) ||
             (c >= 21'h37f && c <= 21'h1fff) || (c >= 21'h200c && c <= 21'h200d) ||
             (c >= 21'h2070 && c <= 21'h218f) || (c >= 21'h2c00 && c <= 21'h2fef) ||
             (c >= 21'h3001 && c <= 21'hd7ff) || (c >= 21'hf900 && c <= 21'hfdcf) ||
             (c >= 21'hfdf0 && c <= 21'hfffd) || (c >= 21'h10000 && c <= 21'heffff);
   endfunction

   // xml ncname character
   function automatic logic dncu_name_char(input code_point_type c);
      return dncu_name_start(c) || (c == 21'h2d) || (c >= 21'h30 && c <= 21'h39) ||
             (c == 21'hb7) || (c >= 21'h300 && c <= 21'h36f) ||
             (c >= 21'h203f && c <= 21'h2040);
   endfunction

endpackage

// ===== rtl/dncu_if.sv =====
// ----------------------------------------------------------------------------
// dncu_req_if / dncu_rsp_if
// Valid/ready channels for string bytes in and check results out.
// ----------------------------------------------------------------------------
interface dncu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface dncu_rsp_if;
   logic       valid;
   logic       ready;
   logic       location_valid;
   logic [1:0] fault_cause;

   modport source (output valid, output location_valid, output fault_cause, input ready);
   modport sink   (input valid, input location_valid, input fault_cause, output ready);
endinterface

// ===== rtl/dotted_ncname_utf8_checker_top.sv =====
// ----------------------------------------------------------------------------
// dotted_ncname_utf8_checker_top
// Checks a byte string as a dot-separated list of XML NCNames in strict UTF-8.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle on req_chan while ready is high,
// the final byte of a string flagged by last_byte, and gives one rsp_chan
// transaction per string: location_valid and the first fault seen (1 bad or
// truncated UTF-8, 2 bad name character, 3 empty segment or trailing dot).
// Bytes pass through an input register and one pass of decode and character
// class logic into the string state and the result register; the result is
// registered as the final byte leaves the input register. Ready drops only
// while a finished result waits on rsp_chan and the next final byte is ready
// to replace it. The block is ready for the next string right after the final
// byte.
module dotted_ncname_utf8_checker_top (
   input logic         clock,
   input logic         reset,
   dncu_req_if.sink    req_chan,
   dncu_rsp_if.source  rsp_chan
);
   import dncu_pkg::*;

   // input register
   logic           s1_valid_ff;
   logic [7:0]     s1_byte_ff;
   logic           s1_last_ff;
   logic           s1_adv;

   // string state
   logic [1:0]     cont_left_ff,  cont_left_in;
   logic [1:0]     seq_len_ff,    seq_len_in;
   code_point_type code_point_ff, code_point_in;
   logic           seg_start_ff,  seg_start_in;
   fault_type      fault_ff,      fault_in;

   // result register
   logic           rsp_valid_ff;
   logic           rsp_loc_ff;
   fault_type      rsp_cause_ff;

   // decode helpers
   code_point_type shifted;
   code_point_type cp_check;
   logic           name_ok;
   logic           bad_value;
   fault_type      final_fault;

   // stage 1 moves on unless a final byte meets a stalled result
   assign s1_adv         = !s1_last_ff || !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_byte_ff <= req_chan.byte_value;
         s1_last_ff <= req_chan.last_byte;
      end
   end

   // utf-8 decode and name character check for one byte
   always_comb begin
      cont_left_in  = cont_left_ff;
      seq_len_in    = seq_len_ff;
      code_point_in = code_point_ff;
      seg_start_in  = seg_start_ff;
      fault_in      = fault_ff;

      shifted   = {code_point_ff[14:0], s1_byte_ff[5:0]};
      cp_check  = (cont_left_ff == 2'd1) ? shifted : {13'd0, s1_byte_ff};
      name_ok   = seg_start_ff ? dncu_name_start(cp_check) : dncu_name_char(cp_check);
      bad_value = (seq_len_ff == SeqThreeByte && shifted < MinThreeByte) ||
                  (seq_len_ff == SeqFourByte && shifted < MinFourByte) ||
                  (shifted >= SurrogateLow && shifted <= SurrogateHigh) ||
                  (shifted > MaxCodePoint);

      if (fault_ff == FaultNone) begin
         if (cont_left_ff != 2'd0) begin
            // continuation byte expected
            if (s1_byte_ff[7:6] != 2'b10) begin
               fault_in = FaultUtf8;
            end else begin
               code_point_in = shifted;
               cont_left_in  = cont_left_ff - 2'd1;
               if (cont_left_ff == 2'd1) begin
                  if (bad_value) begin
                     fault_in = FaultUtf8;
                  end else if (!name_ok) begin
                     fault_in = FaultName;
                  end else begin
                     seg_start_in = 1'b0;
                  end
               end
            end
         end else if (s1_byte_ff == DotByte) begin
            // segment separator
            if (seg_start_ff) begin
               fault_in = FaultEmpty;
            end else begin
               seg_start_in = 1'b1;
            end
         end else if (!s1_byte_ff[7]) begin
            // single byte character
            if (!name_ok) begin
               fault_in = FaultName;
            end else begin
               seg_start_in = 1'b0;
            end
         end else if (s1_byte_ff >= LeadTwoLow && s1_byte_ff <= LeadTwoHigh) begin
            seq_len_in    = SeqTwoByte;
            cont_left_in  = SeqTwoByte;
            code_point_in = {16'd0, s1_byte_ff[4:0]};
         end else if (s1_byte_ff >= LeadThreeLow && s1_byte_ff < LeadFourLow) begin
            seq_len_in    = SeqThreeByte;
            cont_left_in  = SeqThreeByte;
            code_point_in = {17'd0, s1_byte_ff[3:0]};
         end else if (s1_byte_ff >= LeadFourLow && s1_byte_ff <= LeadFourHigh) begin
            seq_len_in    = SeqFourByte;
            cont_left_in  = SeqFourByte;
            code_point_in = {18'd0, s1_byte_ff[2:0]};
         end else begin
            fault_in = FaultUtf8;
         end
      end

      // end of string checks
      final_fault = fault_in;
      if (final_fault == FaultNone && cont_left_in != 2'd0) begin
         final_fault = FaultUtf8;
      end
      if (final_fault == FaultNone && seg_start_in) begin
         final_fault = FaultEmpty;
      end
   end

   // string state, back to its start values after the final byte
   always_ff @(posedge clock) begin
      if (reset) begin
         cont_left_ff  <= 2'd0;
         seq_len_ff    <= 2'd0;
         code_point_ff <= '0;
         seg_start_ff  <= 1'b1;
         fault_ff      <= FaultNone;
      end else if (s1_valid_ff && s1_adv) begin
         if (s1_last_ff) begin
            cont_left_ff  <= 2'd0;
            seq_len_ff    <= 2'd0;
            code_point_ff <= '0;
            seg_start_ff  <= 1'b1;
            fault_ff      <= FaultNone;
         end else begin
            cont_left_ff  <= cont_left_in;
            seq_len_ff    <= seq_len_in;
            code_point_ff <= code_point_in;
            seg_start_ff  <= seg_start_in;
            fault_ff      <= fault_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_valid_ff && s1_last_ff && s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_last_ff && s1_adv) begin
         rsp_loc_ff   <= (final_fault == FaultNone);
         rsp_cause_ff <= final_fault;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.location_valid = rsp_loc_ff;
   assign rsp_chan.fault_cause    = rsp_cause_ff;

endmodule

// ===== rtl/dncu_checker.sv =====
// ----------------------------------------------------------------------------
// dncu_checker
// Port-level assertions for the dotted NCName UTF-8 checker.
// ----------------------------------------------------------------------------
module dncu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       location_valid,
   input logic [1:0] fault_cause
);
   import dncu_pkg::*;

   // a pending result stays until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result transaction dropped before it was taken");

   // a stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(location_valid) && $stable(fault_cause))
      else $error("stalled result payload changed");

   // valid flag agrees with the cause code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (location_valid == (fault_cause == FaultNone)))
      else $error("location_valid disagrees with fault_cause");

   // no result straight after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   // input side only stalls behind a waiting result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid)
      else $error("input stalled with no result waiting");

endmodule

bind dotted_ncname_utf8_checker_top dncu_checker u_dncu_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .location_valid (rsp_chan.location_valid),
   .fault_cause    (rsp_chan.fault_cause)
);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the dotted NCName UTF-8 checker.
// ----------------------------------------------------------------------------
// Strings are queued as byte transactions and driven with random gaps. Each
// accepted byte updates a local copy of the string state. A final byte yields
// an expected verdict, which is compared field by field with the next result
// transaction. A short directed set covers the edge cases. After it come
// random strings, mostly well-formed dotted names with random content, some
// corrupted and some pure byte noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import dncu_pkg::*;

   typedef struct {
      logic [7:0] byte_value;
      logic       last_byte;
      bit         wait_drain;
   } byte_item_type;

   typedef struct {
      logic      location_valid;
      fault_type fault_cause;
   } verdict_type;

   logic clock;
   logic reset;

   dncu_req_if req_chan ();
   dncu_rsp_if rsp_chan ();

   dotted_ncname_utf8_checker_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   byte_item_type pending_bytes[$];
   verdict_type   verdict_q[$];
   int            error_count = 0;
   int            cycle_count = 0;
   bit            req_fired = 0;

   // local copy of the string state
   logic [1:0]     cont_left;
   logic [1:0]     seq_len;
   code_point_type cp_acc;
   logic           seg_start;
   fault_type      fault_seen;

   // ncname character ranges, start characters first
   localparam int NumStartRanges = 15;
   localparam int NumRanges      = 19;
   localparam logic [20:0] RangeLow [NumRanges] = '{
      21'h5f, 21'h41, 21'h61, 21'hc0, 21'hd8, 21'hf8, 21'h370, 21'h37f,
      21'h200c, 21'h2070, 21'h2c00, 21'h3001, 21'hf900, 21'hfdf0, 21'h10000,
      21'h2d, 21'h30, 21'hb7, 21'h300};
   localparam logic [20:0] RangeHigh [NumRanges] = '{
      21'h5f, 21'h5a, 21'h7a, 21'hd6, 21'hf6, 21'h2ff, 21'h37d, 21'h1fff,
      21'h200d, 21'h218f, 21'h2fef, 21'hd7ff, 21'hfdcf, 21'hfffd, 21'heffff,
      21'h2d, 21'h39, 21'hb7, 21'h36f};

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // reset and known levels on every input
   initial begin
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.byte_value = 8'h00;
      req_chan.last_byte  = 1'b0;
      rsp_chan.ready      = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   // class test over the range table
   function automatic bit in_ranges(input code_point_type c, input int count);
      for (int i = 0; i < count; i++)
         if (c >= RangeLow[i] && c <= RangeHigh[i]) return 1'b1;
      return (count == NumRanges) && (c == 21'h203f || c == 21'h2040);
   endfunction

   // random idling, with a quiet stretch that recurs through the run
   function automatic bit take_break();
      if (cycle_count % 4000 >= 300 && cycle_count % 4000 < 900) return 1'b0;
      return $urandom_range(99) < 32;
   endfunction

   task automatic flag_mismatch(input string what);
      error_count++;
      $display("MISMATCH at %0t: %s", $realtime, what);
   endtask

   task automatic clear_string_state();
      cont_left  = 2'd0;
      seq_len    = 2'd0;
      cp_acc     = '0;
      seg_start  = 1'b1;
      fault_seen = FaultNone;
   endtask

   task automatic take_character(input code_point_type c);
      if (!in_ranges(c, seg_start ? NumStartRanges : NumRanges))
         fault_seen = FaultName;
      else
         seg_start = 1'b0;
   endtask

   // one byte through the utf-8 decode and segment tracking
   task automatic absorb_byte(input logic [7:0] b);
      code_point_type v;
      if (cont_left != 2'd0) begin
         if (b[7:6] != 2'b10) begin
            fault_seen = FaultUtf8;
            return;
         end
         v = {cp_acc[14:0], b[5:0]};
         cp_acc = v;
         cont_left = cont_left - 2'd1;
         if (cont_left == 2'd0) begin
            if ((seq_len == SeqThreeByte && v < MinThreeByte) ||
                (seq_len == SeqFourByte && v < MinFourByte) ||
                (v >= SurrogateLow && v <= SurrogateHigh) || v > MaxCodePoint)
               fault_seen = FaultUtf8;
            else
               take_character(v);
         end
         return;
      end
      if (b == DotByte) begin
         if (seg_start) fault_seen = FaultEmpty;
         else seg_start = 1'b1;
         return;
      end
      if (b[7] == 1'b0) begin
         take_character({13'd0, b});
         return;
      end
      if (b >= LeadTwoLow && b <= LeadTwoHigh) begin
         seq_len = SeqTwoByte;
         cp_acc  = {16'd0, b[4:0]};
      end else if (b >= LeadThreeLow && b < LeadFourLow) begin
         seq_len = SeqThreeByte;
         cp_acc  = {17'd0, b[3:0]};
      end else if (b >= LeadFourLow && b <= LeadFourHigh) begin
         seq_len = SeqFourByte;
         cp_acc  = {18'd0, b[2:0]};
      end else begin
         fault_seen = FaultUtf8;
         return;
      end
      cont_left = seq_len;
   endtask

   // expected verdict for an accepted byte, pushed on the final one
   task automatic predict_verdict(input logic [7:0] b, input logic last);
      verdict_type v;
      if (fault_seen == FaultNone) absorb_byte(b);
      if (!last) return;
      if (fault_seen == FaultNone && cont_left != 2'd0) fault_seen = FaultUtf8;
      if (fault_seen == FaultNone && seg_start) fault_seen = FaultEmpty;
      v.location_valid = (fault_seen == FaultNone);
      v.fault_cause    = fault_seen;
      verdict_q.push_back(v);
      clear_string_state();
   endtask

   // request driver
   always @(negedge clock) begin
      byte_item_type item;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_fired) begin
         if (pending_bytes.size() != 0 && !take_break() &&
             !(pending_bytes[0].wait_drain && verdict_q.size() != 0)) begin
            item = pending_bytes.pop_front();
            req_chan.valid      <= 1'b1;
            req_chan.byte_value <= item.byte_value;
            req_chan.last_byte  <= item.last_byte;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // result stall
   always @(negedge clock) begin
      rsp_chan.ready <= !reset && !take_break();
   end

   // monitor: predict on accepted bytes, check result transactions
   always @(posedge clock) begin
      verdict_type exp_v;
      if (reset) begin
         req_fired = 1'b0;
         clear_string_state();
      end else begin
         cycle_count++;
         req_fired = req_chan.valid && req_chan.ready;
         if (req_fired) predict_verdict(req_chan.byte_value, req_chan.last_byte);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (verdict_q.size() == 0) begin
               flag_mismatch("result transaction with no string pending");
            end else begin
               exp_v = verdict_q.pop_front();
               if (rsp_chan.location_valid !== exp_v.location_valid)
                  flag_mismatch($sformatf("location_valid got %0b want %0b",
                                rsp_chan.location_valid, exp_v.location_valid));
               if (rsp_chan.fault_cause !== exp_v.fault_cause)
                  flag_mismatch($sformatf("fault_cause got %0d want %0d",
                                rsp_chan.fault_cause, exp_v.fault_cause));
            end
         end
      end
   end

   // stimulus helpers
   task automatic queue_string(input logic [7:0] s[$], input bit drain_first);
      byte_item_type item;
      for (int i = 0; i < s.size(); i++) begin
         item.byte_value = s[i];
         item.last_byte  = (i == s.size() - 1);
         item.wait_drain = drain_first && (i == 0);
         pending_bytes.push_back(item);
      end
   endtask

   task automatic queue_short(input int count, input logic [7:0] b0,
                              input logic [7:0] b1 = 8'h00, input logic [7:0] b2 = 8'h00,
                              input logic [7:0] b3 = 8'h00);
      logic [7:0] s[$];
      logic [7:0] all [4];
      all = '{b0, b1, b2, b3};
      for (int i = 0; i < count; i++) s.push_back(all[i]);
      queue_string(s, 1'b0);
   endtask

   function automatic int utf8_encode(input code_point_type cp, output logic [7:0] enc [4]);
      enc = '{8'h00, 8'h00, 8'h00, 8'h00};
      if (cp < 21'h80) begin
         enc[0] = cp[7:0];
         return 1;
      end else if (cp < MinThreeByte) begin
         enc[0] = {3'b110, cp[10:6]};
         enc[1] = {2'b10, cp[5:0]};
         return 2;
      end else if (cp < MinFourByte) begin
         enc[0] = {4'b1110, cp[15:12]};
         enc[1] = {2'b10, cp[11:6]};
         enc[2] = {2'b10, cp[5:0]};
         return 3;
      end
      enc[0] = {5'b11110, cp[20:18]};
      enc[1] = {2'b10, cp[17:12]};
      enc[2] = {2'b10, cp[11:6]};
      enc[3] = {2'b10, cp[5:0]};
      return 4;
   endfunction

   // mostly name characters, some boundary code points
   function automatic code_point_type pick_code_point();
      int unsigned sel;
      code_point_type bounds [16];
      bounds = '{21'hb7, 21'hd7, 21'hf7, 21'h2ff, 21'h300, 21'h36f, 21'h37e, 21'h200c,
                 21'h203f, 21'h2040, 21'h2ff0, 21'hd7ff, 21'hfdcf, 21'hfdd0, 21'heffff,
                 21'h10ffff};
      sel = $urandom_range(99);
      if (sel < 40) begin
         case ($urandom_range(2))
            0:       return code_point_type'(21'h41 + $urandom_range(25));
            1:       return code_point_type'(21'h61 + $urandom_range(25));
            default: return 21'h5f;
         endcase
      end
      if (sel < 52) return ($urandom_range(1) != 0) ?
                              code_point_type'(21'h30 + $urandom_range(9)) :
                              code_point_type'($urandom_range(127));
      if (sel < 64) return code_point_type'($urandom_range(21'h7ff, 21'h80));
      if (sel < 80) return code_point_type'($urandom_range(21'hffff, 21'h800));
      if (sel < 90) return code_point_type'($urandom_range(21'h10ffff, 21'h10000));
      return bounds[$urandom_range(15)];
   endfunction

   // stimulus
   initial begin
      logic [7:0] s[$];
      logic [7:0] enc [4];
      logic [7:0] bad_leads [7];
      int n;
      int pos;
      int random_bytes;
      int string_count;
      int unsigned sel;

      bad_leads = '{8'hc0, 8'hc1, 8'he0, 8'hed, 8'hf4, 8'hf5, 8'hff};

      // directed edge cases
      queue_short(1, 8'h61);                         // single letter, valid
      queue_short(1, DotByte);                       // lone dot
      queue_short(2, 8'h61, DotByte);                // trailing dot
      queue_short(3, 8'h61, DotByte, DotByte);       // empty segment
      queue_short(1, 8'h31);                         // digit as name start
      queue_short(1, 8'hff);                         // invalid lead byte
      queue_short(1, 8'hc3);                         // truncated sequence
      queue_short(3, 8'he0, 8'h80, 8'h80);           // overlong three-byte form
      queue_short(3, 8'hed, 8'ha0, 8'h80);           // surrogate
      queue_short(4, 8'hf4, 8'h90, 8'h80, 8'h80);    // above the code point range
      queue_short(2, 8'hc3, DotByte);                // dot inside a sequence
      queue_short(4, 8'hf0, 8'h90, 8'h80, 8'h80);    // smallest four-byte character
      queue_short(3, 8'h5f, DotByte, 8'h5a);         // two segments, valid

      // random strings
      random_bytes = 0;
      string_count = 0;
      while (random_bytes < 1100) begin
         s = {};
         sel = $urandom_range(99);
         if (sel < 15) begin
            // byte noise
            n = $urandom_range(6, 1);
            for (int i = 0; i < n; i++) s.push_back(8'($urandom_range(255)));
         end else begin
            // dotted name with random content
            n = $urandom_range(3, 1);
            for (int seg = 0; seg < n; seg++) begin
               for (int k = $urandom_range(4, 1); k > 0; k--) begin
                  pos = utf8_encode(pick_code_point(), enc);
                  for (int i = 0; i < pos; i++) s.push_back(enc[i]);
               end
               if (seg < n - 1) s.push_back(DotByte);
            end
            sel = $urandom_range(99);
            if (sel >= 70 && sel < 78) begin
               s[$urandom_range(s.size() - 1)] = 8'($urandom_range(255));
            end else if (sel >= 78 && sel < 85 && s.size() > 1) begin
               s.pop_back();
            end else if (sel >= 85 && sel < 90) begin
               s.push_back(DotByte);
            end else if (sel >= 90 && sel < 95) begin
               s.insert($urandom_range(s.size()), DotByte);
            end else if (sel >= 95) begin
               // broken or overlong sequence spliced in
               pos = $urandom_range(s.size());
               for (int i = $urandom_range(3, 1); i > 0; i--)
                  s.insert(pos, 8'h80 | 8'($urandom_range(63)));
               s.insert(pos, bad_leads[$urandom_range(6)]);
            end
         end
         queue_string(s, string_count == 0 || string_count == 90);
         random_bytes += s.size();
         string_count++;
      end

      // drain
      while (pending_bytes.size() != 0 || req_chan.valid) @(posedge clock);
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== dotted_ncname_utf8_checker_top.f =====
rtl/dncu_pkg.sv
rtl/dncu_if.sv
rtl/dotted_ncname_utf8_checker_top.sv
rtl/dncu_checker.sv
dv/tb_top.sv
